[rtl/utr_pkg.sv]
// ----------------------------------------------------------------------------
// utr_pkg
// Types and constants shared by the trajectory resampler modules.
// ----------------------------------------------------------------------------
package utr_pkg;

   localparam int TIME_W         = 31;
   localparam int POS_W          = 32;
   localparam int IDX_W          = 16;
   // grid time stays below sample time plus one interval, so 33 bits hold it
   localparam int GRID_W         = 33;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [TIME_W-1:0] GRID_INTERVAL_RST = TIME_W'(65536);
   localparam logic [IDX_W-1:0]  IDX_MAX           = '1;

   // request item
   typedef struct packed {
      logic [TIME_W-1:0]       sample_time;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    first_sample;
   } req_type;

   // result item
   typedef struct packed {
      logic [TIME_W-1:0]       out_time;
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [POS_W-1:0] out_z;
      logic [IDX_W-1:0]        source_index;
      logic                    last_of_run;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic                    first;
      logic [TIME_W-1:0]       cur_time;
      logic signed [POS_W-1:0] cur_x;
      logic signed [POS_W-1:0] cur_y;
      logic signed [POS_W-1:0] cur_z;
      logic [TIME_W-1:0]       prev_time;
      logic signed [POS_W-1:0] prev_x;
      logic signed [POS_W-1:0] prev_y;
      logic signed [POS_W-1:0] prev_z;
      logic [IDX_W-1:0]        src;
   } cmd_type;

   // queue handshake between front and back
   typedef struct packed {
      logic valid;
   } cmd_stat_type;

   typedef struct packed {
      logic pop;
   } cmd_ctrl_type;

endpackage

[rtl/utr_div.sv]
// ----------------------------------------------------------------------------
// utr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module utr_div #(
   parameter int NUM_W = 63,
   parameter int DEN_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // one step: shift in the next dividend bit and try to subtract
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;
   assign rem  = rem_ff;

endmodule

[rtl/utr_lane.sv]
// ----------------------------------------------------------------------------
// utr_lane
// One coordinate lane: prev + trunc((cur - prev) * grid_off / span), saturated.
// ----------------------------------------------------------------------------
module utr_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [utr_pkg::POS_W-1:0] prev_val,
   input  logic signed [utr_pkg::POS_W-1:0] cur_val,
   input  logic signed [utr_pkg::POS_W-1:0] grid_off,
   input  logic signed [utr_pkg::POS_W-1:0] span,
   output logic                             done,
   output logic signed [utr_pkg::POS_W-1:0] result
);

   localparam int PW = utr_pkg::POS_W;
   localparam int MW = PW - 1;           // magnitude of grid_off and span
   localparam int PRW = PW + MW;         // product width

   logic signed [PW:0]   delta;
   logic signed [PW:0]   delta_neg;
   logic signed [PW-1:0] dist_neg;
   logic signed [PW-1:0] span_neg;

   logic [PW-1:0]        mag_n_ff, mag_n_in;
   logic [MW-1:0]        mag_d_ff, mag_d_in;
   logic [MW-1:0]        mag_f_ff, mag_f_in;
   logic                 neg_ff, neg_in;
   logic signed [PW-1:0] prev_ff, prev_in;
   logic [PRW-1:0]       prod_ff;
   logic                 mul_go_ff;
   logic                 div_go_ff;
   logic                 div_done;
   logic [PRW-1:0]       quo;
   logic [MW-1:0]        rem;
   logic signed [PRW+1:0] q_signed;
   logic signed [PRW+1:0] sum;
   logic signed [PW-1:0] sat;
   logic signed [PW-1:0] result_ff;
   logic                 done_ff;

   // operand magnitudes and result sign
   always_comb begin
      delta     = (PW+1)'(cur_val) - (PW+1)'(prev_val);
      delta_neg = -delta;
      dist_neg  = -grid_off;
      span_neg  = -span;
      mag_n_in  = delta[PW] ? delta_neg[PW-1:0] : delta[PW-1:0];
      mag_d_in  = grid_off[PW-1] ? dist_neg[MW-1:0] : grid_off[MW-1:0];
      mag_f_in  = span[PW-1] ? span_neg[MW-1:0] : span[MW-1:0];
      neg_in    = delta[PW] ^ grid_off[PW-1] ^ span[PW-1];
      prev_in   = prev_val;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_n_ff <= mag_n_in;
         mag_d_ff <= mag_d_in;
         mag_f_ff <= mag_f_in;
         neg_ff   <= neg_in;
         prev_ff  <= prev_in;
      end
      prod_ff <= mag_n_ff * mag_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         mul_go_ff <= start;
         div_go_ff <= mul_go_ff;
      end
   end

   utr_div #(
      .NUM_W (PRW),
      .DEN_W (MW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (prod_ff),
      .den   (mag_f_ff),
      .done  (div_done),
      .quo   (quo),
      .rem   (rem)
   );

   // apply sign, add base value, clamp to 32 bits
   always_comb begin
      q_signed = neg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      sum      = (PRW+2)'(prev_ff) + q_signed;
      if (sum > (PRW+2)'(32'sh7FFFFFFF))
         sat = 32'sh7FFFFFFF;
      else if (sum < (PRW+2)'(-33'sh80000000))
         sat = -32'sh80000000;
      else
         sat = sum[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (div_done && (rem == rem || 1'b1))
         result_ff <= sat;
      if (reset)
         done_ff <= 1'b0;
      else
         done_ff <= div_done;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[rtl/utr_front.sv]
// ----------------------------------------------------------------------------
// utr_front
// Accepts requests, tracks the previous sample, drops zero-length
// segments and queues commands for the back end.
// ----------------------------------------------------------------------------
module utr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  utr_pkg::req_type      req,
   output utr_pkg::cmd_stat_type cmd_stat,
   input  utr_pkg::cmd_ctrl_type cmd_ctrl,
   output utr_pkg::cmd_type      cmd
);

   localparam int DEPTH = 2;

   logic [utr_pkg::TIME_W-1:0]       prev_time_ff;
   logic signed [utr_pkg::POS_W-1:0] prev_x_ff;
   logic signed [utr_pkg::POS_W-1:0] prev_y_ff;
   logic signed [utr_pkg::POS_W-1:0] prev_z_ff;
   logic [utr_pkg::IDX_W-1:0]        count_ff, count_in;

   utr_pkg::cmd_type entries_ff [DEPTH];
   utr_pkg::cmd_type cmd_in;
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff, fill_in;
   logic             accept;
   logic             push;
   logic             pop;

   assign req_ready = (fill_ff != 2'(DEPTH));
   assign accept    = req_valid && req_ready;
   assign push      = accept && (req.first_sample || (req.sample_time != prev_time_ff));
   assign pop       = cmd_ctrl.pop && (fill_ff != 2'd0);

   // build command from this request and the previous sample
   always_comb begin
      cmd_in.first     = req.first_sample;
      cmd_in.cur_time  = req.sample_time;
      cmd_in.cur_x     = req.pos_x;
      cmd_in.cur_y     = req.pos_y;
      cmd_in.cur_z     = req.pos_z;
      cmd_in.prev_time = prev_time_ff;
      cmd_in.prev_x    = prev_x_ff;
      cmd_in.prev_y    = prev_y_ff;
      cmd_in.prev_z    = prev_z_ff;
      cmd_in.src       = count_ff;
   end

   // sample index, saturating
   always_comb begin
      count_in = count_ff;
      if (req.first_sample)
         count_in = '0;
      else if (count_ff != utr_pkg::IDX_MAX)
         count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         prev_time_ff <= req.sample_time;
         prev_x_ff    <= req.pos_x;
         prev_y_ff    <= req.pos_y;
         prev_z_ff    <= req.pos_z;
         count_ff     <= count_in;
      end
   end

   // two-entry command queue
   always_comb begin
      fill_in = fill_ff;
      if (push && !pop)
         fill_in = fill_ff + 2'd1;
      else if (pop && !push)
         fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= cmd_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= !wr_ptr_ff;
         if (pop)
            rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_in;
      end
   end

   assign cmd_stat.valid = (fill_ff != 2'd0);
   assign cmd            = entries_ff[rd_ptr_ff];

endmodule

[rtl/utr_back.sv]
// ----------------------------------------------------------------------------
// utr_back
// Walks the grid over one segment, drives the interpolation lanes and the
// grid skip divider, and holds the result register.
// ----------------------------------------------------------------------------
module utr_back #(
   parameter int MAX_POINTS = utr_pkg::MAX_POINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [utr_pkg::TIME_W-1:0]  grid_interval,
   input  utr_pkg::cmd_stat_type       cmd_stat,
   output utr_pkg::cmd_ctrl_type       cmd_ctrl,
   input  utr_pkg::cmd_type            cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output utr_pkg::rsp_type            rsp
);

   localparam int TW    = utr_pkg::TIME_W;
   localparam int PW    = utr_pkg::POS_W;
   localparam int GW    = utr_pkg::GRID_W;
   localparam int PTS_W = $clog2(MAX_POINTS);
   localparam logic [PTS_W:0] CAP = (PTS_W+1)'(MAX_POINTS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_LANE  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_SKIP  = 3'd5;
   localparam logic [2:0] ST_ADV   = 3'd6;

   logic [2:0]        state_ff, state_in;
   utr_pkg::cmd_type  cmd_ff;
   logic [GW-1:0]     grid_ff, grid_in;
   logic [PTS_W-1:0]  points_ff, points_in;
   logic [TW:0]       steps_ff;
   utr_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [TW-1:0]     dt;
   logic              out_free;
   logic              grid_lt;
   logic              room;
   logic [GW-1:0]     grid_step;
   logic              more;
   logic              lane_start;
   logic              skip_start;
   logic signed [PW-1:0] grid_off;
   logic signed [PW-1:0] span;
   logic [2:0]        lane_done;
   logic signed [PW-1:0] res_x, res_y, res_z;
   logic              skip_done;
   logic [TW-1:0]     skip_quo;
   logic [TW-1:0]     skip_rem;
   logic [TW-1:0]     gap;
   logic [2*TW:0]     adv_prod;

   // a zero interval counts as one
   assign dt       = (grid_interval == '0) ? TW'(1) : grid_interval;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign grid_lt  = grid_ff < GW'(cmd_ff.cur_time);
   assign room     = (PTS_W+1)'(points_ff) < CAP;
   assign grid_step = grid_ff + GW'(dt);
   assign more     = (grid_step < GW'(cmd_ff.cur_time)) &&
                     ((PTS_W+1)'(points_ff) + 1'b1 < CAP);
   assign grid_off = $signed({1'b0, grid_ff[TW-1:0]}) - $signed({1'b0, cmd_ff.prev_time});
   assign span     = $signed({1'b0, cmd_ff.cur_time}) - $signed({1'b0, cmd_ff.prev_time});
   assign gap      = cmd_ff.cur_time - grid_ff[TW-1:0];
   assign adv_prod = steps_ff * dt;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      grid_in      = grid_ff;
      points_in    = points_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_ctrl.pop = 1'b0;
      lane_start   = 1'b0;
      skip_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_stat.valid) begin
               cmd_ctrl.pop = 1'b1;
               state_in     = cmd.first ? ST_FIRST : ST_CHECK;
            end
         end
         ST_FIRST: begin
            if (out_free) begin
               rsp_in.out_time     = cmd_ff.cur_time;
               rsp_in.out_x        = cmd_ff.cur_x;
               rsp_in.out_y        = cmd_ff.cur_y;
               rsp_in.out_z        = cmd_ff.cur_z;
               rsp_in.source_index = '0;
               rsp_in.last_of_run  = 1'b1;
               rsp_valid_in        = 1'b1;
               points_in           = PTS_W'(1);
               grid_in             = GW'(dt);
               state_in            = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (grid_lt && room) begin
               lane_start = 1'b1;
               state_in   = ST_LANE;
            end else if (grid_lt) begin
               skip_start = 1'b1;
               state_in   = ST_SKIP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LANE: begin
            if (&lane_done)
               state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in.out_time     = grid_ff[TW-1:0];
               rsp_in.out_x        = res_x;
               rsp_in.out_y        = res_y;
               rsp_in.out_z        = res_z;
               rsp_in.source_index = cmd_ff.src;
               rsp_in.last_of_run  = !more;
               rsp_valid_in        = 1'b1;
               points_in           = points_ff + 1'b1;
               grid_in             = grid_step;
               state_in            = ST_CHECK;
            end
         end
         ST_SKIP: begin
            if (skip_done)
               state_in = ST_ADV;
         end
         ST_ADV: begin
            grid_in  = grid_ff + adv_prod[GW-1:0];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_ctrl.pop)
         cmd_ff <= cmd;
      if (skip_done)
         steps_ff <= (TW+1)'(skip_quo) + (TW+1)'(skip_rem != '0);
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_ff      <= '0;
         points_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_ff      <= grid_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // coordinate lanes
   utr_lane u_lane_x (
      .clock (clock), .reset (reset), .start (lane_start),
      .prev_val (cmd_ff.prev_x), .cur_val (cmd_ff.cur_x),
      .grid_off (grid_off), .span (span), .done (lane_done[0]), .result (res_x)
   );

   utr_lane u_lane_y (
      .clock (clock), .reset (reset), .start (lane_start),
      .prev_val (cmd_ff.prev_y), .cur_val (cmd_ff.cur_y),
      .grid_off (grid_off), .span (span), .done (lane_done[1]), .result (res_y)
   );

   utr_lane u_lane_z (
      .clock (clock), .reset (reset), .start (lane_start),
      .prev_val (cmd_ff.prev_z), .cur_val (cmd_ff.cur_z),
      .grid_off (grid_off), .span (span), .done (lane_done[2]), .result (res_z)
   );

   // grid skip past the sample when the cap is hit: ceil(gap / dt)
   utr_div #(
      .NUM_W (TW),
      .DEN_W (TW)
   ) u_skip_div (
      .clock (clock),
      .reset (reset),
      .start (skip_start),
      .num   (gap),
      .den   (dt),
      .done  (skip_done),
      .quo   (skip_quo),
      .rem   (skip_rem)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/uniform_time_trajectory_resampler.sv]
// ----------------------------------------------------------------------------
// uniform_time_trajectory_resampler
// Resamples timestamped trajectory samples onto a uniform time grid.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sample per request (time, x, y, z, first_sample flag).
//   rsp_*  : zero or more grid points per request; last_of_run marks the
//            final point a request produced.
//   csr_*  : write of grid_interval (Q15.16); always ready, write only
//            while the block is idle.
// Timing:
//   A first sample passes the command queue and the back end's FIRST
//   state before rsp_valid rises. Each grid point waits for the 63-step
//   serial divider in the three parallel coordinate lanes. Hitting the
//   point cap adds a pass through the grid skip divider.
//   Zero-length segments produce nothing and take no queue slot.
//   A two-entry command queue lets new requests arrive while a result
//   waits in the output register.
// Reset clears the previous sample, grid, counts and queue; grid_interval
// returns to 1.0. A stalled rsp_ready holds the result and the back end;
// the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module uniform_time_trajectory_resampler #(
   parameter int MAX_POINTS = utr_pkg::MAX_POINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  utr_pkg::req_type            req,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output utr_pkg::rsp_type            rsp,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [utr_pkg::TIME_W-1:0]  csr_wdata
);

   logic [utr_pkg::TIME_W-1:0] grid_interval_ff;
   utr_pkg::cmd_stat_type      cmd_stat;
   utr_pkg::cmd_ctrl_type      cmd_ctrl;
   utr_pkg::cmd_type           cmd;

   // interval register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         grid_interval_ff <= utr_pkg::GRID_INTERVAL_RST;
      else if (csr_valid && csr_ready)
         grid_interval_ff <= csr_wdata;
   end

   utr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cmd_stat  (cmd_stat),
      .cmd_ctrl  (cmd_ctrl),
      .cmd       (cmd)
   );

   utr_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .grid_interval (grid_interval_ff),
      .cmd_stat      (cmd_stat),
      .cmd_ctrl      (cmd_ctrl),
      .cmd           (cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp)
   );

endmodule

[rtl/utr_checker.sv]
// ----------------------------------------------------------------------------
// utr_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module utr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input utr_pkg::rsp_type rsp
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   // nothing left in the output register after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // queue is empty after reset, so requests are ready
   a_req_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request not ready after reset");

endmodule

bind uniform_time_trajectory_resampler utr_checker u_utr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

[bench/uniform_time_trajectory_resampler_tb.sv]
// ----------------------------------------------------------------------------
// uniform_time_trajectory_resampler_tb
// Drives trajectory samples into the resampler and checks every grid point
// against an in-bench predictor of the interpolation, the point cap and the
// grid bookkeeping. Both handshake sides idle at random; the grid interval
// is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uniform_time_trajectory_resampler_tb;

   localparam int                         CAP      = utr_pkg::MAX_POINTS_DEF - 1;
   localparam logic [utr_pkg::TIME_W-1:0] TIME_MAX = '1;
   localparam logic [utr_pkg::POS_W-1:0]  POS_MAX  = 32'h7fff_ffff;
   localparam logic [utr_pkg::POS_W-1:0]  POS_MIN  = 32'h8000_0000;
   localparam logic [utr_pkg::TIME_W-1:0] ONE      = 31'h1_0000;
   localparam int                         SETTLE   = 150;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   utr_pkg::req_type req = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   utr_pkg::rsp_type rsp;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [utr_pkg::TIME_W-1:0] csr_wdata = '0;

   // predictor state
   logic [utr_pkg::TIME_W-1:0]       grid_step;
   logic [utr_pkg::TIME_W-1:0]       last_time;
   logic signed [utr_pkg::POS_W-1:0] last_x, last_y, last_z;
   longint                           grid_time;
   int                               traj_points;
   int                               sample_idx;

   utr_pkg::rsp_type pending_points[$];
   int      error_count = 0;
   int      requests_sent = 0;
   int      points_checked = 0;
   int      interval_writes = 0;
   bit      quiet = 1'b0;

   uniform_time_trajectory_resampler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // exact linear interpolation, truncated toward zero, then saturated
   function automatic logic signed [utr_pkg::POS_W-1:0] lerp(
         logic signed [utr_pkg::POS_W-1:0] p,
         logic signed [utr_pkg::POS_W-1:0] c, longint d, longint f);
      logic signed [127:0] pw, cw, dw, fw, r;
      pw = p;
      cw = c;
      dw = d;
      fw = f;
      r = pw + ((cw - pw) * dw) / fw;
      if (r > 128'sh7fff_ffff) r = 128'sh7fff_ffff;
      if (r < -128'sh8000_0000) r = -128'sh8000_0000;
      return r[utr_pkg::POS_W-1:0];
   endfunction

   // expected grid points for one accepted request
   function automatic void resample(utr_pkg::req_type r);
      longint           dt, f, tt, gap;
      int               n;
      utr_pkg::rsp_type pt;
      dt = (grid_step == 0) ? 1 : longint'(grid_step);
      tt = longint'(r.sample_time);
      n = 0;
      if (r.first_sample) begin
         pt = '{r.sample_time, r.pos_x, r.pos_y, r.pos_z, '0, 1'b1};
         pending_points.push_back(pt);
         traj_points = 1;
         sample_idx = 0;
         grid_time = dt;
      end else if (r.sample_time != last_time) begin
         f = tt - longint'(last_time);
         while (grid_time < tt && traj_points < CAP && n < 64) begin
            pt.out_time     = grid_time[utr_pkg::TIME_W-1:0];
            pt.out_x        = lerp(last_x, r.pos_x, grid_time - longint'(last_time), f);
            pt.out_y        = lerp(last_y, r.pos_y, grid_time - longint'(last_time), f);
            pt.out_z        = lerp(last_z, r.pos_z, grid_time - longint'(last_time), f);
            pt.source_index = sample_idx[utr_pkg::IDX_W-1:0];
            pt.last_of_run  = 1'b0;
            pending_points.push_back(pt);
            n++;
            traj_points++;
            grid_time += dt;
         end
         if (grid_time < tt) begin
            gap = tt - grid_time;
            grid_time += ((gap + dt - 1) / dt) * dt;
         end
         if (n > 0) pending_points[$].last_of_run = 1'b1;
      end
      if (!r.first_sample && sample_idx < 65535) sample_idx++;
      last_time = r.sample_time;
      last_x = r.pos_x;
      last_y = r.pos_y;
      last_z = r.pos_z;
   endfunction

   function automatic utr_pkg::req_type sample(logic [utr_pkg::TIME_W-1:0] t,
         logic [utr_pkg::POS_W-1:0] x, logic [utr_pkg::POS_W-1:0] y,
         logic [utr_pkg::POS_W-1:0] z, logic first);
      utr_pkg::req_type r;
      r.sample_time = t;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.first_sample = first;
      return r;
   endfunction

   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      $display("mismatch at %0t: %s expected %h got %h", $realtime, field, want, got);
      error_count++;
   endtask

   // send one request; valid stays high across back-to-back requests
   task automatic send(utr_pkg::req_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      do @(posedge clock); while (!req_ready);
      resample(r);
      requests_sent++;
   endtask

   // drop valid, wait for all points, then let trailing work finish
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_interval(logic [utr_pkg::TIME_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      grid_step = v;
      interval_writes++;
   endtask

   // result side: random stalls, compare against the oldest expectation
   initial begin : result_check
      int               stall;
      utr_pkg::rsp_type want;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (pending_points.size() == 0) begin
            report("unexpected point", '0, 64'(rsp.out_time));
         end else begin
            want = pending_points.pop_front();
            if (rsp.out_time != want.out_time)
               report("out_time", 64'(want.out_time), 64'(rsp.out_time));
            if (rsp.out_x != want.out_x)
               report("out_x", 64'(want.out_x), 64'(rsp.out_x));
            if (rsp.out_y != want.out_y)
               report("out_y", 64'(want.out_y), 64'(rsp.out_y));
            if (rsp.out_z != want.out_z)
               report("out_z", 64'(want.out_z), 64'(rsp.out_z));
            if (rsp.source_index != want.source_index)
               report("source_index", 64'(want.source_index), 64'(rsp.source_index));
            if (rsp.last_of_run != want.last_of_run)
               report("last_of_run", 64'(want.last_of_run), 64'(rsp.last_of_run));
            points_checked++;
         end
      end
   end

   // sample before any trajectory start, then a zero-length segment
   task automatic test_no_trajectory();
      send(sample(31'h3_8000, 32'h1_0000, -32'sh2_0000, 32'h0, 1'b0));
      send(sample(31'h3_8000, 32'h5_0000, 32'h5_0000, 32'h5_0000, 1'b0));
   endtask

   // field extremes, saturation, decreasing time and extrapolation
   task automatic test_extremes();
      send(sample(TIME_MAX, POS_MAX, POS_MIN, 32'h0, 1'b1));
      send(sample(31'h0, 32'hffff_ffff, POS_MAX, POS_MIN, 1'b1));
      send(sample(31'h2_8000, POS_MIN, POS_MIN, POS_MAX, 1'b0));
      send(sample(31'h1_0000, POS_MAX, POS_MAX, POS_MIN, 1'b0));
      send(sample(31'h5_0000, POS_MAX, POS_MIN, 32'h1234_5678, 1'b1));
      send(sample(31'h6_0000, POS_MIN, POS_MAX, 32'hedcb_a987, 1'b0));
      send(sample(31'h5_8000, 32'h0, 32'h0, 32'h0, 1'b0));
   endtask

   // zero interval acts as one LSB; a long segment hits the point cap
   task automatic test_point_cap();
      write_interval('0);
      send(sample(31'h0, 32'h0, 32'h0, 32'h0, 1'b1));
      send(sample(31'd200, 32'h1000, -32'sh1000, 32'h7, 1'b0));
      send(sample(31'd300, 32'h2000, 32'h2000, 32'h9, 1'b0));
      send(sample(31'd10, 32'h1, 32'h2, 32'h3, 1'b1));
      send(sample(31'd14, 32'h40, 32'h80, 32'hc0, 1'b0));
   endtask

   // largest interval, then an interval change inside a trajectory
   task automatic test_interval_change();
      write_interval(TIME_MAX);
      send(sample(31'h0, 32'h100, 32'h200, 32'h300, 1'b1));
      send(sample(TIME_MAX, POS_MAX, POS_MIN, 32'h0, 1'b0));
      write_interval(31'h4000_0000);
      send(sample(31'h0, 32'h0, 32'h0, 32'h0, 1'b1));
      send(sample(TIME_MAX, POS_MIN, POS_MAX, POS_MAX, 1'b0));
      write_interval(ONE);
      send(sample(31'h0, 32'h0, 32'h1_0000, 32'h0, 1'b1));
      send(sample(31'h2_8000, 32'h5_0000, 32'h0, 32'h0, 1'b0));
      write_interval(31'h8000);
      send(sample(31'h4_0000, 32'h8_0000, -32'sh4_0000, 32'h1, 1'b0));
   endtask

   // random trajectories: mostly well-formed, some noise
   task automatic test_random(int count);
      int                         sent, len;
      logic [utr_pkg::TIME_W-1:0] t, dt;
      longint                     nxt;
      bit                         drained;
      sent = 0;
      drained = 1'b0;
      while (sent < count) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: write_interval(31'h4000);
               1: write_interval(ONE);
               2: write_interval(31'h3_0000);
               default: write_interval(utr_pkg::TIME_W'($urandom_range(1, 31'h4_0000)));
            endcase
         end
         if (!drained && sent > count / 2) begin
            drain();
            drained = 1'b1;
         end
         quiet = ($urandom_range(0, 3) == 0);
         dt = (grid_step == 0) ? 31'd1 : grid_step;
         t = ($urandom_range(0, 4) == 0) ? utr_pkg::TIME_W'($urandom) :
             utr_pkg::TIME_W'($urandom_range(0, 2 * dt));
         send(sample(t, $urandom, $urandom, $urandom, 1'b1));
         sent++;
         len = $urandom_range(2, 7);
         repeat (len) begin
            if ($urandom_range(0, 9) == 0) begin
               t = utr_pkg::TIME_W'($urandom);
            end else if ($urandom_range(0, 7) != 0) begin
               nxt = longint'(t) + $urandom_range(0, 3 * dt);
               t = (nxt > longint'(TIME_MAX)) ? TIME_MAX : utr_pkg::TIME_W'(nxt);
            end
            send(sample(t, $urandom, $urandom, $urandom, 1'b0));
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin : stimulus
      grid_step = utr_pkg::GRID_INTERVAL_RST;
      last_time = '0;
      last_x = '0;
      last_y = '0;
      last_z = '0;
      grid_time = 0;
      traj_points = 0;
      sample_idx = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_trajectory();
      test_extremes();
      test_point_cap();
      test_interval_change();
      test_random(85);
      drain();
      $display("covered %0d requests, %0d grid points, %0d interval writes",
               requests_sent, points_checked, interval_writes);
      $display("including pre-start samples, cap overflow, saturation and mid-run steps");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #60_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
